// ----- design/tlh_pkg.sv -----
// tlh_pkg: shared types and constants for the thermal level block
// level codes, queue entry and config write bundle; no dependencies

package tlh_pkg;

  localparam int TEMP_W = 16;
  localparam int DEG_W  = 10;
  localparam int LVL_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [LVL_W-1:0] LVL_LOW      = 2'd0;
  localparam logic [LVL_W-1:0] LVL_HIGH     = 2'd1;
  localparam logic [LVL_W-1:0] LVL_THROTTLE = 2'd2;
  localparam logic [LVL_W-1:0] LVL_CRIT     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_ON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_ON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAN_ON      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAN_OFF     = 2'd3;

  localparam logic signed [DEG_W-1:0] CRITICAL_ON_RST = 10'sd85;
  localparam logic signed [DEG_W-1:0] THROTTLE_ON_RST = 10'sd70;
  localparam logic signed [DEG_W-1:0] FAN_ON_RST      = 10'sd45;
  localparam logic signed [DEG_W-1:0] FAN_OFF_RST     = 10'sd40;

  // hysteresis below the critical and throttle on-thresholds, whole degrees
  localparam logic signed [DEG_W:0] HYST_DEG = 11'sd2;

  // x / 100 as (x * 5243) >> 19, exact for magnitudes up to 32768
  localparam int DIV_MUL_W = 13;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 13'd5243;
  localparam int DIV_SHIFT = 19;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic                    cmd;
    logic signed [DEG_W-1:0] temp_deg;
  } qent_t;

  typedef struct packed {
    logic                    we;
    logic [CFG_IDX_W-1:0]    index;
    logic [DEG_W-1:0]        wdata;
  } cfg_wr_t;

endpackage

// ----- design/tlh_in_if.sv -----
// tlh_in_if: input channel, one temperature sample per beat
// depends on tlh_pkg

interface tlh_in_if import tlh_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [TEMP_W-1:0] temp_centideg;

  modport source (output valid, cmd, temp_centideg, input ready);
  modport sink (input valid, cmd, temp_centideg, output ready);
endinterface

// ----- design/tlh_out_if.sv -----
// tlh_out_if: result channel, one thermal level per beat
// depends on tlh_pkg

interface tlh_out_if import tlh_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [LVL_W-1:0]        thermal_level;
  logic                    level_changed;
  logic signed [DEG_W-1:0] temp_whole_deg;

  modport source (output valid, thermal_level, level_changed, temp_whole_deg, input ready);
  modport sink (input valid, thermal_level, level_changed, temp_whole_deg, output ready);
endinterface

// ----- design/tlh_front.sv -----
// tlh_front: accepts samples and converts centidegrees to whole degrees
// depends on tlh_pkg and tlh_in_if; feeds tlh_queue

module tlh_front import tlh_pkg::*; (
  tlh_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       push,
  output qent_t      push_data
);

  logic                          neg;
  logic [TEMP_W:0]               mag;
  logic [TEMP_W+DIV_MUL_W:0]     prod;
  logic [DEG_W-1:0]              quot;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // truncate toward zero: divide the magnitude, then restore the sign
  always_comb begin
    neg  = in_ch.temp_centideg[TEMP_W-1];
    mag  = neg ? (~{in_ch.temp_centideg[TEMP_W-1], in_ch.temp_centideg} + 1'b1)
               : {1'b0, in_ch.temp_centideg};
    prod = {{DIV_MUL_W{1'b0}}, mag} * {{(TEMP_W+1){1'b0}}, DIV_MUL};
    quot = prod[DIV_SHIFT+DEG_W-1:DIV_SHIFT];
    push_data.cmd      = in_ch.cmd;
    push_data.temp_deg = neg ? (~quot + 1'b1) : quot;
  end

endmodule

// ----- design/tlh_queue.sv -----
// tlh_queue: two-entry queue between front and back
// depends on tlh_pkg

module tlh_queue import tlh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output qent_t pop_data,
  output logic  empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("push into full queue");

endmodule

// ----- design/tlh_back.sv -----
// tlh_back: threshold registers, level state machine and output register
// depends on tlh_pkg and tlh_out_if; drains tlh_queue

module tlh_back import tlh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_wr_t    cfg,
  input  logic       q_empty,
  input  qent_t      q_data,
  output logic       pop,
  tlh_out_if.source  out_ch
);

  logic signed [DEG_W-1:0] critical_on_deg;
  logic signed [DEG_W-1:0] throttle_on_deg;
  logic signed [DEG_W-1:0] fan_on_deg;
  logic signed [DEG_W-1:0] fan_off_deg;

  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] level_next;
  logic [LVL_W-1:0] rise_lvl;
  logic             out_valid;

  logic signed [DEG_W:0] t_ext;
  logic                  ge_crit;
  logic                  ge_thr;
  logic                  ge_fan_on;
  logic                  lt_fan_off;
  logic                  lt_crit_hyst;
  logic                  lt_thr_hyst;

  assign pop = !q_empty && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      critical_on_deg <= CRITICAL_ON_RST;
      throttle_on_deg <= THROTTLE_ON_RST;
      fan_on_deg      <= FAN_ON_RST;
      fan_off_deg     <= FAN_OFF_RST;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_CRITICAL_ON: critical_on_deg <= cfg.wdata;
        REG_THROTTLE_ON: throttle_on_deg <= cfg.wdata;
        REG_FAN_ON:      fan_on_deg      <= cfg.wdata;
        REG_FAN_OFF:     fan_off_deg     <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // hysteresis compares run one bit wider so threshold - 2 cannot wrap
  always_comb begin
    t_ext        = {q_data.temp_deg[DEG_W-1], q_data.temp_deg};
    ge_crit      = q_data.temp_deg >= critical_on_deg;
    ge_thr       = q_data.temp_deg >= throttle_on_deg;
    ge_fan_on    = q_data.temp_deg >= fan_on_deg;
    lt_fan_off   = q_data.temp_deg < fan_off_deg;
    lt_crit_hyst = t_ext < ($signed({critical_on_deg[DEG_W-1], critical_on_deg}) - HYST_DEG);
    lt_thr_hyst  = t_ext < ($signed({throttle_on_deg[DEG_W-1], throttle_on_deg}) - HYST_DEG);

    if (ge_crit)        rise_lvl = LVL_CRIT;
    else if (ge_thr)    rise_lvl = LVL_THROTTLE;
    else if (ge_fan_on) rise_lvl = LVL_HIGH;
    else                rise_lvl = LVL_LOW;

    if (q_data.cmd) begin
      level_next = rise_lvl;
    end else begin
      case (level)
        LVL_LOW: level_next = rise_lvl;
        LVL_HIGH: begin
          if (ge_crit)         level_next = LVL_CRIT;
          else if (ge_thr)     level_next = LVL_THROTTLE;
          else if (lt_fan_off) level_next = LVL_LOW;
          else                 level_next = LVL_HIGH;
        end
        LVL_THROTTLE: begin
          if (ge_crit)          level_next = LVL_CRIT;
          else if (lt_thr_hyst) level_next = LVL_HIGH;
          else                  level_next = LVL_THROTTLE;
        end
        default: level_next = lt_crit_hyst ? LVL_THROTTLE : LVL_CRIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= LVL_LOW;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        level     <= level_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.thermal_level  <= level_next;
      out_ch.level_changed  <= (level_next != level);
      out_ch.temp_whole_deg <= q_data.temp_deg;
    end
  end

  assign out_ch.valid = out_valid;

  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_ch.thermal_level == level)
    else $error("shown level differs from stored level");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_ch.level_changed == (level != $past(level)))
    else $error("level_changed disagrees with state update");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !pop |=> level == $past(level))
    else $error("level moved without a popped item");

endmodule

// ----- design/thermal_level_hysteresis_fsm_core.sv -----
// thermal_level_hysteresis_fsm_core: top level of the thermal level block
// depends on tlh_pkg, tlh_in_if, tlh_out_if, tlh_front, tlh_queue, tlh_back
//
// usage:
//   in_ch carries one sample per beat: cmd (0 step, 1 classify from low) and
//   temp_centideg, signed hundredths of a degree. out_ch returns one beat per
//   sample: thermal_level, level_changed and temp_whole_deg (sample / 100,
//   truncated toward zero). cfg_we/cfg_index/cfg_wdata write the four
//   thresholds in whole degrees, one per cycle, while the block is idle.
// timing:
//   the front converts the sample in the accept cycle and writes a two-entry
//   queue; the back pops one entry per cycle, while the output register is
//   empty or being taken, through the level state machine into the output
//   register. a result passes the queue and then the output register;
//   throughput is one sample per cycle while out_ch.ready stays high.
// reset (rst, synchronous): level low, thresholds 85/70/45/40, queue empty.
// stall: when out_ch.ready is low the result holds, the back stops popping,
//   and in_ch.ready drops once the queue holds two samples.

module thermal_level_hysteresis_fsm_core import tlh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  tlh_in_if.sink               in_ch,
  tlh_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DEG_W-1:0]     cfg_wdata
);

  logic    push;
  qent_t   push_data;
  logic    q_full;
  logic    q_empty;
  logic    pop;
  qent_t   q_data;
  cfg_wr_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  tlh_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  tlh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  tlh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
